// ===== rtl/rs485_frame_receiver_top_assert.svh =====
// Assertion macros shared by the frame receiver RTL.
`ifndef RS485_FRAME_RECEIVER_TOP_ASSERT_SVH
`define RS485_FRAME_RECEIVER_TOP_ASSERT_SVH

// Check that a condition holds on every clock outside reset.
`define RS485FR_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// Check that the consequent holds in the same cycle as the antecedent.
`define RS485FR_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define RS485FR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/rs485fr_pkg.sv =====
// Constants and codes of the frame receiver.
`default_nettype none
package rs485fr_pkg;

    localparam int ByteW   = 8;
    localparam int GapW    = 16;
    localparam int PosW    = 9;
    localparam int CfgIdxW = 2;

    localparam logic [ByteW-1:0] HeaderByte    = 8'hF5;
    localparam logic [ByteW-1:0] BroadcastAddr = 8'hFF;
    localparam logic [ByteW-1:0] QueryCmd      = 8'h01;

    localparam logic [ByteW-1:0] OwnAddrReset  = 8'd1;
    localparam logic [GapW-1:0]  GapTicksReset = 16'd200;
    localparam logic [GapW-1:0]  IdleMax       = 16'hFFFF;

    localparam logic [PosW-1:0] PosHeader  = 9'd0;
    localparam logic [PosW-1:0] PosAddress = 9'd1;
    localparam logic [PosW-1:0] PosCommand = 9'd2;
    localparam logic [PosW-1:0] PosLength  = 9'd3;
    localparam logic [PosW-1:0] PosPayload = 9'd4;
    localparam logic [PosW-1:0] PosMax     = 9'd259;

    localparam logic OpByte = 1'b0;
    localparam logic OpTick = 1'b1;

    localparam logic [CfgIdxW-1:0] CfgOwnAddress = 2'd0;
    localparam logic [CfgIdxW-1:0] CfgGapTicks   = 2'd1;

endpackage
`default_nettype wire

// ===== rtl/rs485fr_if.sv =====
// Valid/ready channel interfaces of the frame receiver.
`default_nettype none
interface rs485fr_in_if;
    logic                            valid;
    logic                            ready;
    logic                            op;
    logic [rs485fr_pkg::ByteW-1:0]   rx_byte;

    modport source (output valid, output op, output rx_byte, input ready);
    modport sink   (input valid, input op, input rx_byte, output ready);
endinterface

interface rs485fr_out_if;
    logic                            valid;
    logic                            ready;
    logic [rs485fr_pkg::ByteW-1:0]   command;
    logic                            is_query;
    logic                            broadcast;
    logic [rs485fr_pkg::ByteW-1:0]   payload_length;

    modport source (output valid, output command, output is_query, output broadcast,
                    output payload_length, input ready);
    modport sink   (input valid, input command, input is_query, input broadcast,
                    input payload_length, output ready);
endinterface

interface rs485fr_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [rs485fr_pkg::CfgIdxW-1:0]  index;
    logic [rs485fr_pkg::GapW-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/rs485_frame_receiver_top.sv =====
// Frame receiver: header/address check, length walk and additive checksum over payload bytes.
//
// Input channel i_in carries one beat per received byte (op 0) or per time tick (op 1).
// Output channel o_out carries one beat per frame whose checksum matched: command,
// query flag, broadcast flag and payload length. Bad frames give no beat.
// Configuration channel i_cfg writes own_address (index 0) or gap_ticks (index 1); it is
// always ready. The user must use it only while the receiver is idle (not enforced).
// Path: an input beat waits in the input register, the parser updates combinationally and
// a result is written to the output register, where it stays valid until o_out takes it.
// Throughput: one beat per cycle while the output register is not stalled, set by the
// combinational parser update between the input register and the output register.
// Reset: frame search restarts at the header, idle counter saturates, own_address
// returns to 1 and gap_ticks to 200.
// Stall: while a result waits in the output register and o_out.ready is low the
// parser holds; one more beat waits in the input register, then i_in.ready drops.
`default_nettype none
`include "rs485_frame_receiver_top_assert.svh"
module rs485_frame_receiver_top (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    rs485fr_in_if.sink          i_in,
    rs485fr_cfg_if.sink         i_cfg,
    rs485fr_out_if.source       o_out
);
    import rs485fr_pkg::*;

    logic               r_in_valid;
    logic               r_in_op;
    logic [ByteW-1:0]   r_in_byte;

    logic [ByteW-1:0]   r_own_address;
    logic [GapW-1:0]    r_gap_ticks;

    logic [PosW-1:0]    r_pos,        n_pos;
    logic [ByteW-1:0]   r_length,     n_length;
    logic [ByteW-1:0]   r_sum,        n_sum;
    logic [ByteW-1:0]   r_command,    n_command;
    logic               r_broadcast,  n_broadcast;
    logic [GapW-1:0]    r_idle,       n_idle;

    logic               r_out_valid;
    logic [ByteW-1:0]   r_out_command;
    logic               r_out_is_query;
    logic               r_out_broadcast;
    logic [ByteW-1:0]   r_out_length;

    logic               w_adv;
    logic               w_fire;
    logic               w_result;
    logic [PosW-1:0]    w_pos;
    logic [PosW-1:0]    w_check_pos;

    assign w_adv       = !r_out_valid || o_out.ready;
    assign w_fire      = r_in_valid && w_adv;
    assign i_in.ready  = !r_in_valid || w_adv;
    assign i_cfg.ready = 1'b1;
    assign w_pos       = (r_idle > r_gap_ticks) ? PosHeader : r_pos;
    assign w_check_pos = PosPayload + {1'b0, r_length};

    always_comb begin
        n_pos       = r_pos;
        n_length    = r_length;
        n_sum       = r_sum;
        n_command   = r_command;
        n_broadcast = r_broadcast;
        n_idle      = r_idle;
        w_result    = 1'b0;
        if (r_in_op == OpTick) begin
            if (r_idle != IdleMax) begin
                n_idle = r_idle + 1'b1;
            end
        end else begin
            n_idle = '0;
            if (w_pos == PosHeader) begin
                n_pos = (r_in_byte == HeaderByte) ? PosAddress : PosHeader;
                n_sum = '0;
            end else if (w_pos == PosAddress) begin
                if (r_in_byte == r_own_address || r_in_byte == BroadcastAddr) begin
                    n_broadcast = (r_in_byte == BroadcastAddr);
                    n_pos       = PosCommand;
                end else begin
                    n_pos = PosHeader;
                end
            end else if (w_pos == PosCommand) begin
                n_command = r_in_byte;
                n_pos     = PosLength;
            end else if (w_pos == PosLength) begin
                n_length = r_in_byte;
                n_sum    = '0;
                n_pos    = PosPayload;
            end else if (w_pos >= w_check_pos) begin
                w_result = (r_in_byte == r_sum);
                n_pos    = PosHeader;
                n_length = '0;
                n_sum    = '0;
            end else begin
                n_sum = r_sum + r_in_byte;
                n_pos = w_pos + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
        if (i_in.ready) begin
            r_in_op   <= i_in.op;
            r_in_byte <= i_in.rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_address <= OwnAddrReset;
            r_gap_ticks   <= GapTicksReset;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CfgOwnAddress: r_own_address <= i_cfg.data[ByteW-1:0];
                CfgGapTicks:   r_gap_ticks   <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= PosHeader;
            r_length    <= '0;
            r_sum       <= '0;
            r_command   <= '0;
            r_broadcast <= 1'b0;
            r_idle      <= IdleMax;
        end else if (w_fire) begin
            r_pos       <= n_pos;
            r_length    <= n_length;
            r_sum       <= n_sum;
            r_command   <= n_command;
            r_broadcast <= n_broadcast;
            r_idle      <= n_idle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_fire && w_result;
        end
        if (w_fire && w_result) begin
            r_out_command   <= r_command;
            r_out_is_query  <= (r_command == QueryCmd);
            r_out_broadcast <= r_broadcast;
            r_out_length    <= r_length;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.command        = r_out_command;
    assign o_out.is_query       = r_out_is_query;
    assign o_out.broadcast      = r_out_broadcast;
    assign o_out.payload_length = r_out_length;

    `RS485FR_ASSERT_ALWAYS(a_pos_range, r_pos <= PosMax, "frame position out of range")
    `RS485FR_ASSERT_NEXT(a_no_spurious_result, !r_out_valid && !w_fire, !r_out_valid,
        "result appeared without a processed beat")
    `RS485FR_ASSERT_NEXT(a_tick_counts, w_fire && r_in_op == OpTick, r_idle != '0,
        "tick left idle counter at zero")
    `RS485FR_ASSERT_SAME(a_query_flag, r_out_valid,
        r_out_is_query == (r_out_command == QueryCmd), "query flag disagrees with command")

endmodule
`default_nettype wire

// ===== tb/tb_rs485_frame_receiver_top.sv =====
// Self-checking testbench for the frame receiver: predicted frame reports against the output channel.
module tb_rs485_frame_receiver_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rs485fr_pkg::*;

    localparam int StallLimit  = 3000;
    localparam int HoldCycles  = 400;
    localparam int DrainCycles = 6;

    typedef struct packed {
        logic [ByteW-1:0] command;
        logic             is_query;
        logic             broadcast;
        logic [ByteW-1:0] payload_length;
    } t_frame_report;

    typedef struct packed {
        logic             op;
        logic [ByteW-1:0] rx_byte;
    } t_beat;

    class t_frame_checker;
        logic [ByteW-1:0] own_addr;
        logic [GapW-1:0]  gap_limit;
        logic [PosW-1:0]  pos;
        logic [ByteW-1:0] frame_len;
        logic [ByteW-1:0] sum;
        logic [ByteW-1:0] cmd;
        logic             bcast;
        logic [GapW-1:0]  idle;
        t_frame_report    awaited[$];
        int               errors;

        function new();
            own_addr  = OwnAddrReset;
            gap_limit = GapTicksReset;
            pos       = PosHeader;
            frame_len = '0;
            sum       = '0;
            cmd       = '0;
            bcast     = 1'b0;
            idle      = IdleMax;
            errors    = 0;
        endfunction

        function void write_reg(logic [CfgIdxW-1:0] idx, logic [GapW-1:0] value);
            if (idx == CfgOwnAddress) begin
                own_addr = value[ByteW-1:0];
            end else if (idx == CfgGapTicks) begin
                gap_limit = value;
            end
        endfunction

        function void take_beat(logic op, logic [ByteW-1:0] b);
            t_frame_report rep;
            if (op == OpTick) begin
                if (idle != IdleMax) begin
                    idle = idle + 1'b1;
                end
                return;
            end
            if (idle > gap_limit) begin
                pos = PosHeader;
            end
            idle = '0;
            if (pos == PosHeader) begin
                pos = (b == HeaderByte) ? PosAddress : PosHeader;
                sum = '0;
            end else if (pos == PosAddress) begin
                if (b == own_addr || b == BroadcastAddr) begin
                    bcast = (b == BroadcastAddr);
                    pos   = PosCommand;
                end else begin
                    pos = PosHeader;
                end
            end else if (pos == PosCommand) begin
                cmd = b;
                pos = PosLength;
            end else if (pos == PosLength) begin
                frame_len = b;
                sum       = '0;
                pos       = PosPayload;
            end else if (pos >= PosPayload + {1'b0, frame_len}) begin
                if (b == sum) begin
                    rep.command        = cmd;
                    rep.is_query       = (cmd == QueryCmd);
                    rep.broadcast      = bcast;
                    rep.payload_length = frame_len;
                    awaited.push_back(rep);
                end
                pos       = PosHeader;
                frame_len = '0;
                sum       = '0;
            end else begin
                sum = sum + b;
                pos = pos + 1'b1;
            end
        endfunction

        function void check_report(t_frame_report got);
            t_frame_report want;
            if (awaited.size() == 0) begin
                $error("unexpected frame report: command %0h length %0d",
                       got.command, got.payload_length);
                errors++;
                return;
            end
            want = awaited.pop_front();
            if (got.command !== want.command) begin
                $error("command: expected %0h, got %0h", want.command, got.command);
                errors++;
            end
            if (got.is_query !== want.is_query) begin
                $error("is_query: expected %0b, got %0b", want.is_query, got.is_query);
                errors++;
            end
            if (got.broadcast !== want.broadcast) begin
                $error("broadcast: expected %0b, got %0b", want.broadcast, got.broadcast);
                errors++;
            end
            if (got.payload_length !== want.payload_length) begin
                $error("payload_length: expected %0d, got %0d",
                       want.payload_length, got.payload_length);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    rs485fr_in_if  in_ch ();
    rs485fr_out_if out_ch ();
    rs485fr_cfg_if cfg_ch ();

    rs485_frame_receiver_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    t_frame_checker frames = new();
    t_beat          stim_beats[$];
    t_frame_report  seen_report;
    bit             no_idling;
    bit             hold_req;
    int             stall_left;

    initial begin
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.op       = OpByte;
        in_ch.rx_byte  = '0;
        out_ch.ready   = 1'b0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.index   = CfgOwnAddress;
        cfg_ch.data    = '0;
        no_idling      = 1'b0;
        hold_req       = 1'b0;
        stall_left     = 0;
    end

    always #1 i_clk = ~i_clk;

    // Result side: random stall bursts, plus one long hold-off on request.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready = 1'b0;
        end else if (hold_req) begin
            out_ch.ready = 1'b0;
            stall_left   = HoldCycles;
            hold_req     = 1'b0;
        end else if (stall_left > 0) begin
            out_ch.ready = 1'b0;
            stall_left--;
        end else if (!no_idling && $urandom_range(0, 7) == 0) begin
            out_ch.ready = 1'b0;
            stall_left   = $urandom_range(1, 18) - 1;
        end else begin
            out_ch.ready = 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            seen_report.command        = out_ch.command;
            seen_report.is_query       = out_ch.is_query;
            seen_report.broadcast      = out_ch.broadcast;
            seen_report.payload_length = out_ch.payload_length;
            frames.check_report(seen_report);
        end
    end

    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < StallLimit) begin
            @(posedge i_clk);
            if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("Some tests failed");
        $finish;
    end

    function automatic void queue_byte(logic [ByteW-1:0] b);
        t_beat t;
        t.op      = OpByte;
        t.rx_byte = b;
        stim_beats.push_back(t);
    endfunction

    function automatic void queue_ticks(int n);
        t_beat t;
        t.op = OpTick;
        repeat (n) begin
            t.rx_byte = 8'($urandom);
            stim_beats.push_back(t);
        end
    endfunction

    function automatic void queue_frame(logic [ByteW-1:0] addr, logic [ByteW-1:0] cmd,
                                        logic [ByteW-1:0] len, bit good_sum,
                                        int tick_odds, int tick_top, int cut_at);
        logic [ByteW-1:0] body[$];
        logic [ByteW-1:0] sum;
        logic [ByteW-1:0] pl;
        logic [ByteW-1:0] flip;
        sum = '0;
        body.push_back(HeaderByte);
        body.push_back(addr);
        body.push_back(cmd);
        body.push_back(len);
        for (int i = 0; i < int'(len); i++) begin
            pl  = 8'($urandom);
            sum = sum + pl;
            body.push_back(pl);
        end
        flip = 8'($urandom_range(1, 255));
        body.push_back(good_sum ? sum : sum ^ flip);
        for (int i = 0; i < body.size(); i++) begin
            if (i == cut_at) begin
                break;
            end
            if (i > 0 && tick_odds > 0 && $urandom_range(1, tick_odds) == 1) begin
                queue_ticks($urandom_range(1, tick_top));
            end
            queue_byte(body[i]);
        end
    endfunction

    // Mostly well-formed frames with random content, the rest noise bytes and tick runs.
    function automatic void queue_random(int n_items, logic [ByteW-1:0] own,
                                         logic [GapW-1:0] gap);
        int               r;
        int               sel;
        int               cut;
        int               tick_top;
        logic [ByteW-1:0] addr;
        logic [ByteW-1:0] cmd;
        logic [ByteW-1:0] len;
        logic [ByteW-1:0] noise;
        tick_top = (gap < 6) ? int'(gap) + 2 : 3;
        while (stim_beats.size() < n_items) begin
            r = $urandom_range(0, 99);
            if (r < 78) begin
                sel = $urandom_range(0, 7);
                if (sel < 4) begin
                    addr = own;
                end else if (sel < 6) begin
                    addr = BroadcastAddr;
                end else begin
                    addr = 8'($urandom);
                end
                if ($urandom_range(0, 3) == 0) begin
                    cmd = QueryCmd;
                end else begin
                    cmd = 8'($urandom);
                end
                if ($urandom_range(0, 39) == 0) begin
                    len = ($urandom_range(0, 1) == 1) ? 8'hFF : 8'($urandom);
                end else begin
                    len = 8'($urandom_range(0, 6));
                end
                cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, int'(len) + 4) : -1;
                queue_frame(addr, cmd, len, $urandom_range(0, 6) != 0, 6, tick_top, cut);
            end else if (r < 90) begin
                repeat ($urandom_range(1, 4)) begin
                    noise = ($urandom_range(0, 3) == 0) ? HeaderByte : 8'($urandom);
                    queue_byte(noise);
                end
            end else begin
                queue_ticks($urandom_range(1, tick_top));
            end
        end
    endfunction

    task automatic send_beats();
        t_beat bt;
        while (stim_beats.size() > 0) begin
            bt = stim_beats.pop_front();
            @(negedge i_clk);
            if (!no_idling && $urandom_range(0, 7) == 0) begin
                in_ch.valid = 1'b0;
                repeat ($urandom_range(1, 18)) @(negedge i_clk);
            end
            in_ch.op      = bt.op;
            in_ch.rx_byte = bt.rx_byte;
            in_ch.valid   = 1'b1;
            do @(posedge i_clk); while (!in_ch.ready);
            frames.take_beat(bt.op, bt.rx_byte);
        end
        @(negedge i_clk);
        in_ch.valid = 1'b0;
    endtask

    task automatic settle();
        while (frames.awaited.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    task automatic write_register(logic [CfgIdxW-1:0] idx, logic [GapW-1:0] value);
        @(negedge i_clk);
        cfg_ch.index = idx;
        cfg_ch.data  = value;
        cfg_ch.valid = 1'b1;
        do @(posedge i_clk); while (!cfg_ch.ready);
        frames.write_reg(idx, value);
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    initial begin
        logic [ByteW-1:0] own_pick;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset settings: query frame, bad header, bad address, broadcast, bad checksum.
        queue_frame(OwnAddrReset, QueryCmd, 8'd0, 1'b1, 0, 1, -1);
        queue_byte(8'h00);
        queue_byte(HeaderByte);
        queue_byte(8'h02);
        queue_frame(BroadcastAddr, 8'hFF, 8'd1, 1'b1, 0, 1, -1);
        queue_frame(OwnAddrReset, 8'h00, 8'd2, 1'b0, 0, 1, -1);
        queue_ticks(2);
        // Abandon a partial frame after a gap just past the reset tick count.
        queue_byte(HeaderByte);
        queue_byte(OwnAddrReset);
        queue_ticks(int'(GapTicksReset) + 1);
        queue_frame(OwnAddrReset, 8'h3C, 8'd3, 1'b1, 0, 1, -1);
        queue_random(520, OwnAddrReset, GapTicksReset);
        send_beats();
        settle();

        write_register(CfgOwnAddress, 16'h00FF);
        write_register(CfgGapTicks, 16'd0);
        queue_random(250, 8'hFF, 16'd0);
        send_beats();
        settle();

        write_register(CfgOwnAddress, 16'h0000);
        write_register(CfgGapTicks, 16'hFFFF);
        queue_random(330, 8'h00, 16'hFFFF);
        send_beats();
        settle();

        own_pick = 8'($urandom);
        write_register(CfgOwnAddress, {8'h00, own_pick});
        write_register(CfgGapTicks, 16'd3);
        queue_random(400, own_pick, 16'd3);
        hold_req = 1'b1;
        send_beats();
        settle();

        write_register(CfgOwnAddress, 16'h005A);
        write_register(CfgGapTicks, 16'd1);
        no_idling = 1'b1;
        queue_random(400, 8'h5A, 16'd1);
        send_beats();
        settle();

        if (frames.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+rtl
rtl/rs485fr_pkg.sv
rtl/rs485fr_if.sv
rtl/rs485_frame_receiver_top.sv
tb/tb_rs485_frame_receiver_top.sv
